// File: hw/rtl/lcd_fw_pkg.sv
// Shared types and constants for the serial LCD frame writer.
`timescale 1ns / 1ps
`default_nettype none

package lcd_fw_pkg;

    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_START = 2'd1,
        OP_CONT  = 2'd2
    } opcode_t;

    localparam logic [2:0] ID_CMD   = 3'b100;
    localparam logic [2:0] ID_WRITE = 3'b101;

    localparam int          HDR_W          = 12;
    localparam logic [3:0]  CMD_FRAME_BITS = 4'd12;
    localparam logic [3:0]  HDR_BITS       = 4'd9;
    localparam int          DATA_W         = 32;
    localparam int          CNT_W          = 6;

    // Everything the serialiser needs to run one item.
    typedef struct packed {
        logic [HDR_W-1:0]  hdr;        // header bits, left aligned, sent MSB first
        logic [3:0]        hdr_cnt;
        logic [DATA_W-1:0] data;       // data bits, sent LSB first
        logic [CNT_W-1:0]  data_cnt;
        logic              close;
        logic              single;     // one result without a clocked bit
        logic              single_rel;
        logic              single_err;
    } load_t;

endpackage

`default_nettype wire

// File: hw/rtl/lcd_driver_serial_frame_writer.sv
// Top level of the three-wire segment LCD serial frame writer.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item produces one output word per serial bit, one word per
// cycle while the output side keeps up: 12 words for a command, 9 plus the
// saturated bit count for a write start, the bit count (at least one word)
// for a continue, and a single word for a misplaced opcode. The figure is set
// by the header and data shift registers, which move one bit per cycle while
// the output side keeps up. The next item is taken in the cycle after the last
// word of the current one has entered the output register.
module lcd_driver_serial_frame_writer
    import lcd_fw_pkg::*;
#(
    parameter int CHUNK_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [7:0]        s_command_code,
    input  wire logic [5:0]        s_address,
    input  wire logic [DATA_W-1:0] s_data_bits,
    input  wire logic [CNT_W-1:0]  s_bit_count,
    input  wire logic              s_close_frame,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_bit_value,
    output logic                   m_bit_valid,
    output logic                   m_select_release,
    output logic                   m_run_last,
    output logic                   m_error
);

    logic  accept;
    load_t load;

    assign accept = s_valid && s_ready;

    lcd_fw_decode #(
        .CHUNK_BITS(CHUNK_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .opcode      (s_opcode),
        .command_code(s_command_code),
        .address     (s_address),
        .data_bits   (s_data_bits),
        .bit_count   (s_bit_count),
        .close_frame (s_close_frame),
        .load        (load)
    );

    lcd_fw_serial u_serial (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load_en         (accept),
        .load            (load),
        .ready           (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bit_value     (m_bit_value),
        .m_bit_valid     (m_bit_valid),
        .m_select_release(m_select_release),
        .m_run_last      (m_run_last),
        .m_error         (m_error)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lcd_fw_decode.sv
// Opcode decoder and frame state for the serial LCD frame writer.
`timescale 1ns / 1ps
`default_nettype none

module lcd_fw_decode
    import lcd_fw_pkg::*;
#(
    parameter int CHUNK_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [1:0]        opcode,
    input  wire logic [7:0]        command_code,
    input  wire logic [5:0]        address,
    input  wire logic [DATA_W-1:0] data_bits,
    input  wire logic [CNT_W-1:0]  bit_count,
    input  wire logic              close_frame,
    output load_t                  load
);

    localparam logic [CNT_W-1:0] CHUNK_LIM = CNT_W'(CHUNK_BITS);

    logic             frame_open_reg;
    logic             frame_open_next;
    logic [CNT_W-1:0] cnt_sat;

    assign cnt_sat = (bit_count > CHUNK_LIM) ? CHUNK_LIM : bit_count;

    always_comb begin
        load            = '0;
        load.data       = data_bits;
        frame_open_next = frame_open_reg;
        unique case (opcode)
            OP_CMD: begin
                if (frame_open_reg) begin
                    load.single     = 1'b1;
                    load.single_err = 1'b1;
                end else begin
                    load.hdr     = {ID_CMD, command_code, 1'b0};
                    load.hdr_cnt = CMD_FRAME_BITS;
                    load.close   = 1'b1;
                end
            end
            OP_START: begin
                if (frame_open_reg) begin
                    load.single     = 1'b1;
                    load.single_err = 1'b1;
                end else begin
                    load.hdr        = {ID_WRITE, address, 3'b000};
                    load.hdr_cnt    = HDR_BITS;
                    load.data_cnt   = cnt_sat;
                    load.close      = close_frame;
                    frame_open_next = !close_frame;
                end
            end
            OP_CONT: begin
                if (!frame_open_reg) begin
                    load.single     = 1'b1;
                    load.single_err = 1'b1;
                end else begin
                    // An empty chunk still yields one result carrying the close flag.
                    load.single     = (cnt_sat == '0);
                    load.single_rel = close_frame;
                    load.data_cnt   = cnt_sat;
                    load.close      = close_frame;
                    frame_open_next = !close_frame;
                end
            end
            default: begin
                load.single     = 1'b1;
                load.single_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
        end else if (accept) begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_fw_serial.sv
// Bit serialiser with header and data shift registers and an output register.
`timescale 1ns / 1ps
`default_nettype none

module lcd_fw_serial
    import lcd_fw_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  load_en,
    input  wire load_t load,
    output logic       ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic       m_bit_value,
    output logic       m_bit_valid,
    output logic       m_select_release,
    output logic       m_run_last,
    output logic       m_error
);

    logic              busy_reg, busy_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic [3:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]  data_cnt_reg, data_cnt_next;
    logic              close_reg, single_reg, single_rel_reg, single_err_reg;

    logic out_valid_reg, out_valid_next;
    logic out_bit_reg, out_bvalid_reg, out_rel_reg, out_last_reg, out_err_reg;

    logic emit;
    logic e_bit, e_bvalid, e_rel, e_last, e_err;

    assign emit  = busy_reg && (!out_valid_reg || m_ready);
    assign ready = !busy_reg;

    always_comb begin
        hdr_next      = hdr_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        data_next     = data_reg;
        data_cnt_next = data_cnt_reg;
        e_bit         = 1'b0;
        e_bvalid      = 1'b0;
        e_rel         = 1'b0;
        e_last        = 1'b1;
        e_err         = 1'b0;
        if (single_reg) begin
            e_rel = single_rel_reg;
            e_err = single_err_reg;
        end else if (hdr_cnt_reg != '0) begin
            e_bit        = hdr_reg[HDR_W-1];
            e_bvalid     = 1'b1;
            e_last       = (hdr_cnt_reg == 4'd1) && (data_cnt_reg == '0);
            e_rel        = e_last && close_reg;
            hdr_next     = {hdr_reg[HDR_W-2:0], 1'b0};
            hdr_cnt_next = hdr_cnt_reg - 4'd1;
        end else begin
            // Zero fill on the left (MSB end) makes positions past the chunk read as zero.
            e_bit         = data_reg[0];
            e_bvalid      = 1'b1;
            e_last        = (data_cnt_reg == CNT_W'(1));
            e_rel         = e_last && close_reg;
            data_next     = {1'b0, data_reg[DATA_W-1:1]};
            data_cnt_next = data_cnt_reg - CNT_W'(1);
        end
        busy_next = busy_reg;
        if (load_en) begin
            busy_next = 1'b1;
        end else if (emit && e_last) begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            hdr_reg        <= load.hdr;
            hdr_cnt_reg    <= load.hdr_cnt;
            data_reg       <= load.data;
            data_cnt_reg   <= load.data_cnt;
            close_reg      <= load.close;
            single_reg     <= load.single;
            single_rel_reg <= load.single_rel;
            single_err_reg <= load.single_err;
        end else if (emit) begin
            hdr_reg      <= hdr_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            data_reg     <= data_next;
            data_cnt_reg <= data_cnt_next;
        end
        if (emit) begin
            out_bit_reg    <= e_bit;
            out_bvalid_reg <= e_bvalid;
            out_rel_reg    <= e_rel;
            out_last_reg   <= e_last;
            out_err_reg    <= e_err;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_bit_value      = out_bit_reg;
    assign m_bit_valid      = out_bvalid_reg;
    assign m_select_release = out_rel_reg;
    assign m_run_last       = out_last_reg;
    assign m_error          = out_err_reg;

    // A new item is only loaded once the previous one has fully left the shifter.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |-> !busy_reg)
        else $error("item loaded while the serialiser was busy");

    // A busy shifter always has something left to send.
    a_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (single_reg || hdr_cnt_reg != '0 || data_cnt_reg != '0))
        else $error("serialiser busy with no bits left");

    // A word without a clocked bit is always a lone, final word.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_bvalid_reg) |-> (out_last_reg && !out_bit_reg))
        else $error("unclocked word is not final or carries data");

    // An error never releases select.
    a_err_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_err_reg) |-> (!out_rel_reg && !out_bvalid_reg))
        else $error("error word with select release or data");

endmodule

`default_nettype wire

// File: tb/lcd_driver_serial_frame_writer_tb.sv
// Self-checking testbench for the serial LCD frame writer, with its scoreboard.
`timescale 1ns / 1ps

module lcd_driver_serial_frame_writer_tb;
    import lcd_fw_pkg::*;

    localparam int          CHUNK_BITS   = 32;
    localparam logic [1:0]  OP_ILLEGAL   = 2'd3;
    localparam int          RESET_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          RANDOM_ITEMS = 140;
    localparam int          REPORT_MAX   = 10;

    typedef struct packed {
        logic bit_value;
        logic bit_valid;
        logic select_release;
        logic run_last;
        logic error;
    } serial_word_t;

    // Tracks the open frame and holds the serial words still owed by the block.
    class frame_scoreboard;
        bit           frame_open;
        serial_word_t owed_words[$];
        int unsigned  items_noted;
        int unsigned  words_checked;
        int unsigned  error_words;
        int unsigned  frames_closed;
        int unsigned  mismatches;

        function new();
            frame_open    = 1'b0;
            items_noted   = 0;
            words_checked = 0;
            error_words   = 0;
            frames_closed = 0;
            mismatches    = 0;
        endfunction

        function void owe(logic b, logic v, logic rel, logic last, logic err);
            serial_word_t w;
            w.bit_value      = b;
            w.bit_valid      = v;
            w.select_release = rel;
            w.run_last       = last;
            w.error          = err;
            owed_words.push_back(w);
        endfunction

        function void owe_error();
            error_words++;
            owe(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        endfunction

        // Data goes out least significant bit first; positions past the chunk read as zero.
        function void owe_data(logic [DATA_W-1:0] data, int unsigned n, logic close);
            logic b;
            for (int unsigned i = 0; i < n; i++) begin
                b = (i < DATA_W) ? data[i] : 1'b0;
                owe(b, 1'b1, (i == n - 1) && close, i == n - 1, 1'b0);
            end
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] cmd, logic [5:0] addr,
                                logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt_in,
                                logic close);
            int unsigned  n;
            logic [11:0]  cmd_frame;
            logic [8:0]   hdr;
            logic         last;
            items_noted++;
            n = (cnt_in > CHUNK_BITS) ? CHUNK_BITS : 32'(cnt_in);
            case (op)
                OP_CMD: begin
                    if (frame_open) begin
                        owe_error();
                    end else begin
                        // A command frame is complete in itself and always releases select.
                        cmd_frame = {ID_CMD, cmd, 1'b0};
                        for (int i = 0; i < 12; i++) begin
                            last = (i == 11);
                            owe(cmd_frame[11 - i], 1'b1, last, last, 1'b0);
                        end
                    end
                end
                OP_START: begin
                    if (frame_open) begin
                        owe_error();
                    end else begin
                        hdr = {ID_WRITE, addr};
                        for (int i = 0; i < 9; i++) begin
                            last = (i == 8) && (n == 0);
                            owe(hdr[8 - i], 1'b1, last && close, last, 1'b0);
                        end
                        owe_data(data, n, close);
                        frame_open = !close;
                        if (close) frames_closed++;
                    end
                end
                OP_CONT: begin
                    if (!frame_open) begin
                        owe_error();
                    end else begin
                        if (n == 0) owe(1'b0, 1'b0, close, 1'b1, 1'b0);
                        else owe_data(data, n, close);
                        frame_open = !close;
                        if (close) frames_closed++;
                    end
                end
                default: owe_error();
            endcase
        endfunction

        function void check_word(serial_word_t got);
            serial_word_t want;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("tb: word %b arrived with nothing owed", got);
                return;
            end
            want = owed_words.pop_front();
            words_checked++;
            if (got.bit_value !== want.bit_value || got.bit_valid !== want.bit_valid ||
                got.select_release !== want.select_release ||
                got.run_last !== want.run_last || got.error !== want.error) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"tb: word %0d mismatch (value valid release last error)",
                              " expected %b %b %b %b %b, got %b %b %b %b %b"},
                             words_checked, want.bit_value, want.bit_valid,
                             want.select_release, want.run_last, want.error,
                             got.bit_value, got.bit_valid, got.select_release,
                             got.run_last, got.error);
            end
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_opcode;
    logic [7:0]        s_command_code;
    logic [5:0]        s_address;
    logic [DATA_W-1:0] s_data_bits;
    logic [CNT_W-1:0]  s_bit_count;
    logic              s_close_frame;
    logic              m_valid;
    logic              m_ready;
    logic              m_bit_value;
    logic              m_bit_valid;
    logic              m_select_release;
    logic              m_run_last;
    logic              m_error;

    frame_scoreboard   sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       hold_requests;
    int unsigned       holds_served;

    lcd_driver_serial_frame_writer #(
        .CHUNK_BITS(CHUNK_BITS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_command_code   (s_command_code),
        .s_address        (s_address),
        .s_data_bits      (s_data_bits),
        .s_bit_count      (s_bit_count),
        .s_close_frame    (s_close_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bit_value      (m_bit_value),
        .m_bit_valid      (m_bit_valid),
        .m_select_release (m_select_release),
        .m_run_last       (m_run_last),
        .m_error          (m_error)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offers one item, idling first at the current rate, and notes it once taken.
    task automatic send_item(logic [1:0] op, logic [7:0] cmd, logic [5:0] addr,
                             logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt,
                             logic close);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_command_code <= cmd;
        s_address      <= addr;
        s_data_bits    <= data;
        s_bit_count    <= cnt;
        s_close_frame  <= close;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, cmd, addr, data, cnt, close);
    endtask

    // Mostly short chunks, some longer ones up to the chunk size, and a few above it.
    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return CNT_W'($urandom_range(0, 12));
        if (roll < 90) return CNT_W'($urandom_range(13, CHUNK_BITS));
        return CNT_W'($urandom_range(CHUNK_BITS + 1, 63));
    endfunction

    // A write frame: a start and up to four continues; the close rides on the last item sent.
    task automatic send_write_frame();
        int unsigned n_cont;
        logic        close_now;
        n_cont    = $urandom_range(0, 4);
        close_now = (n_cont == 0) || ($urandom_range(0, 99) < 10);
        send_item(OP_START, 8'($urandom), 6'($urandom), $urandom, pick_count(), close_now);
        for (int unsigned i = 0; i < n_cont && !close_now; i++) begin
            close_now = (i == n_cont - 1);
            send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, pick_count(),
                      close_now);
        end
    endtask

    task automatic send_random_phase(int unsigned n_items);
        int unsigned start_count;
        start_count = sb.items_noted;
        while (sb.items_noted - start_count < n_items) begin
            case ($urandom_range(0, 9))
                0, 1:    send_item(OP_CMD, 8'($urandom), 6'($urandom), $urandom,
                                   6'($urandom), 1'($urandom));
                2:       send_item(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom),
                                   $urandom, 6'($urandom), 1'($urandom));
                default: send_write_frame();
            endcase
        end
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 11;
        recv_idle_pct  = 73;
        hold_requests  = 0;
        holds_served   = 0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_opcode       <= OP_CMD;
        s_command_code <= '0;
        s_address      <= '0;
        s_data_bits    <= '0;
        s_bit_count    <= '0;
        s_close_frame  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Misplaced opcodes with no frame open, then command frames.
        send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, 6'd5, 1'b0);
        send_item(OP_ILLEGAL, 8'($urandom), 6'($urandom), $urandom, 6'($urandom),
                  1'($urandom));
        send_item(OP_CMD, 8'h00, 6'h00, 32'h0, 6'd0, 1'b0);
        // The close flag of a command has no effect.
        send_item(OP_CMD, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 6'd63, 1'b1);
        // A header-only frame that closes on its last header bit.
        send_item(OP_START, 8'($urandom), 6'h00, $urandom, 6'd0, 1'b1);
        send_item(OP_START, 8'($urandom), 6'h3F, 32'hFFFF_FFFF, 6'd32, 1'b0);
        send_item(OP_START, 8'($urandom), 6'($urandom), $urandom, 6'($urandom),
                  1'($urandom));
        send_item(OP_CMD, 8'($urandom), 6'($urandom), $urandom, 6'($urandom),
                  1'($urandom));
        send_item(OP_ILLEGAL, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 6'd63, 1'b1);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, 6'd0, 1'b0);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), 32'h0, 6'd32, 1'b0);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, 6'd63, 1'b0);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), 32'hAAAA_5555, 6'd33, 1'b0);
        // An empty continue that closes the frame.
        send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, 6'd0, 1'b1);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, 6'd3, 1'b1);
        send_item(OP_START, 8'($urandom), 6'h2A, 32'h5555_AAAA, 6'd40, 1'b1);
        send_item(OP_START, 8'($urandom), 6'h15, 32'h0000_0001, 6'd1, 1'b0);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), 32'hFFFF_FFFE, 6'd1, 1'b1);
        send_item(OP_START, 8'($urandom), 6'h0F, $urandom, 6'd0, 1'b0);
        send_item(OP_CONT, 8'($urandom), 6'($urandom), $urandom, 6'd7, 1'b1);
        send_item(OP_CMD, 8'hA5, 6'($urandom), $urandom, 6'($urandom), 1'($urandom));

        send_random_phase(RANDOM_ITEMS / 3);
        send_idle_pct = 73;
        recv_idle_pct = 11;
        send_random_phase(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // The receiver stops for a long while so the block backs up into its input.
        hold_requests = hold_requests + 1;
        send_random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d items, %0d serial words checked, %0d of them error words,",
                 sb.items_noted, sb.words_checked, sb.error_words);
        $display("tb: %0d write frames closed, %0d mismatches, %0d words never seen",
                 sb.frames_closed, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random back-pressure, and the long hold when one is asked for.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served < hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served = holds_served + 1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word({m_bit_value, m_bit_valid, m_select_release, m_run_last,
                           m_error});
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb: nothing accepted for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
